/* hdl/process_min_heap_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// process min-heap scheduler assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef PROCESS_MIN_HEAP_SCHEDULER_DEFINES_SVH
`define PROCESS_MIN_HEAP_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PMHS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PMHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pmhs_pkg.sv */
// ----------------------------------------------------------------------------
// pmhs_pkg
// types and constants shared by the process min-heap scheduler modules
// ----------------------------------------------------------------------------
package pmhs_pkg;

  // default sizes
  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;

  // fixed field widths
  localparam int PRIO_W   = 7;
  localparam int BURST_W  = 10;
  localparam int KEY_W    = 10;
  localparam int OUT_ID_W = 16;
  localparam int CFG_W    = 1;

  // operation codes
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    cmd_t                cmd;
    logic [PRIO_W-1:0]   new_priority;
    logic [BURST_W-1:0]  new_burst;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t             status;
    logic [OUT_ID_W-1:0] proc_id;
    logic [PRIO_W-1:0]   proc_priority;
    logic [BURST_W-1:0]  proc_burst;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_TOP,
    S_POP_LAST,
    S_POP_SETUP,
    S_DN_LEFT,
    S_DN_LCMP,
    S_DN_RCMP,
    S_DN_MOVE,
    S_EMIT
  } state_t;

  // heap position update
  typedef enum logic [2:0] {
    POS_HOLD,
    POS_TAIL,
    POS_ROOT,
    POS_PARENT,
    POS_BEST
  } pos_op_t;

  // heap memory read address source
  typedef enum logic [2:0] {
    RD_PARENT,
    RD_ROOT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // heap memory write data source
  typedef enum logic [1:0] {
    WR_ITEM,
    WR_READ,
    WR_BEST
  } wr_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    accept;
    pos_op_t pos_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    top_ld;
    logic    moved_ld;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    best_left;
    logic    best_right;
    logic    res_ld;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic in_pop;
    logic full;
    logic empty;
    logic count_one;
    logic pos_root;
    logic parent_le;
    logic left_in;
    logic right_in;
    logic best_vld;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/pmhs_ctrl.sv */
// ----------------------------------------------------------------------------
// pmhs_ctrl
// sequencer for push sift-up and pop sift-down over the heap memory
// ----------------------------------------------------------------------------
module pmhs_ctrl
  import pmhs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (stat.in_pop) begin
            state_nxt = stat.empty ? S_EMIT : S_POP_TOP;
          end else if (stat.full) begin
            state_nxt = S_EMIT;
          end else begin
            ctl.pos_op = POS_TAIL;
            state_nxt  = S_UP_CHK;
          end
        end
      end
      // sift up: stop at root or fetch parent
      S_UP_CHK: begin
        if (stat.pos_root) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_sel  = WR_ITEM;
          ctl.cnt_inc = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        if (stat.parent_le) begin
          ctl.wr_sel  = WR_ITEM;
          ctl.cnt_inc = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          ctl.wr_sel = WR_READ;
          ctl.pos_op = POS_PARENT;
          state_nxt  = S_UP_CHK;
        end
      end
      // pop: fetch root and last entry
      S_POP_TOP: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_ROOT;
        state_nxt  = S_POP_LAST;
      end
      S_POP_LAST: begin
        ctl.top_ld = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_LAST;
        state_nxt  = S_POP_SETUP;
      end
      S_POP_SETUP: begin
        ctl.moved_ld = 1'b1;
        ctl.cnt_dec  = 1'b1;
        ctl.pos_op   = POS_ROOT;
        state_nxt    = stat.count_one ? S_EMIT : S_DN_LEFT;
      end
      // sift down: fetch children, pick the smaller, move it up
      S_DN_LEFT: begin
        if (stat.left_in) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_LEFT;
          state_nxt  = S_DN_LCMP;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = WR_ITEM;
          state_nxt  = S_EMIT;
        end
      end
      S_DN_LCMP: begin
        ctl.best_left = 1'b1;
        if (stat.right_in) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_RIGHT;
          state_nxt  = S_DN_RCMP;
        end else begin
          state_nxt = S_DN_MOVE;
        end
      end
      S_DN_RCMP: begin
        ctl.best_right = 1'b1;
        state_nxt      = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        ctl.wr_en = 1'b1;
        if (stat.best_vld) begin
          ctl.wr_sel = WR_BEST;
          ctl.pos_op = POS_BEST;
          state_nxt  = S_DN_LEFT;
        end else begin
          ctl.wr_sel = WR_ITEM;
          state_nxt  = S_EMIT;
        end
      end
      // hand the result to the output register
      S_EMIT: begin
        if (stat.out_free) begin
          ctl.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pmhs_dp.sv */
// ----------------------------------------------------------------------------
// pmhs_dp
// heap memory, counters, key compare and output register of the scheduler
// ----------------------------------------------------------------------------
module pmhs_dp
  import pmhs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_ctl_t          ctl,
  output dp_stat_t         stat,
  input  logic             out_stall,
  output logic             out_valid,
  output out_item_t        out_data
);

  localparam int ENTRY_W = ID_BITS + PRIO_W + BURST_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = $clog2(CAPACITY);

  // entry layout: id, priority, burst
  function automatic logic [KEY_W-1:0] key_of(logic sel, logic [ENTRY_W-1:0] e);
    logic [KEY_W-1:0] k;
    if (sel) begin
      k = KEY_W'(e[BURST_W-1:0]);
    end else begin
      k = KEY_W'(e[BURST_W +: PRIO_W]);
    end
    return k;
  endfunction

  logic [ENTRY_W-1:0] heap_mem [CAPACITY];

  logic               key_sel_r;
  logic [CNT_W-1:0]   count_r;
  logic [ID_BITS-1:0] next_id_r;
  logic [CNT_W-1:0]   pos_r;
  logic [CNT_W-1:0]   pos_nxt;
  logic [ENTRY_W-1:0] item_r;
  logic [ENTRY_W-1:0] top_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] best_r;
  logic [CNT_W-1:0]   best_pos_r;
  logic               best_vld_r;
  status_t            st_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [CNT_W-1:0]   parent_pos;
  logic [CNT_W-1:0]   parent_m1;
  logic [CNT_W-1:0]   count_m1;
  logic [CNT_W-1:0]   pos_m1;
  logic [CNT_W:0]     left_w;
  logic [CNT_W:0]     left_m1;
  logic [CNT_W:0]     right_w;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   item_key;
  logic [KEY_W-1:0]   best_key;
  logic [ENTRY_W-1:0] res_src;
  logic [31:0]        res_id_ext;
  logic               out_free;

  // position arithmetic (1-based heap positions)
  assign parent_pos = pos_r >> 1;
  assign parent_m1  = parent_pos - CNT_W'(1);
  assign count_m1   = count_r - CNT_W'(1);
  assign pos_m1     = pos_r - CNT_W'(1);
  assign left_w     = {pos_r, 1'b0};
  assign left_m1    = left_w - (CNT_W + 1)'(1);
  assign right_w    = left_w + (CNT_W + 1)'(1);

  // keys
  assign rd_key   = key_of(key_sel_r, rd_data_r);
  assign item_key = key_of(key_sel_r, item_r);
  assign best_key = best_vld_r ? key_of(key_sel_r, best_r) : item_key;

  // read address select
  always_comb begin
    unique case (ctl.rd_sel)
      RD_PARENT: rd_addr = parent_m1[ADDR_W-1:0];
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = count_m1[ADDR_W-1:0];
      RD_LEFT:   rd_addr = left_m1[ADDR_W-1:0];
      RD_RIGHT:  rd_addr = left_w[ADDR_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  // write data select, written at the current position
  assign wr_addr = pos_m1[ADDR_W-1:0];
  always_comb begin
    unique case (ctl.wr_sel)
      WR_ITEM: wr_data = item_r;
      WR_READ: wr_data = rd_data_r;
      WR_BEST: wr_data = best_r;
      default: wr_data = item_r;
    endcase
  end

  // heap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= heap_mem[rd_addr];
    end
  end

  // next position
  always_comb begin
    unique case (ctl.pos_op)
      POS_HOLD:   pos_nxt = pos_r;
      POS_TAIL:   pos_nxt = count_r + CNT_W'(1);
      POS_ROOT:   pos_nxt = CNT_W'(1);
      POS_PARENT: pos_nxt = parent_pos;
      POS_BEST:   pos_nxt = best_pos_r;
      default:    pos_nxt = pos_r;
    endcase
  end

  // control state: key select, fill count, id counter, result status, position, best flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_sel_r  <= 1'b0;
      count_r    <= '0;
      next_id_r  <= '0;
      best_vld_r <= 1'b0;
      st_r       <= ST_PUSHED;
      pos_r      <= CNT_W'(1);
    end else begin
      if (cfg_we) begin
        key_sel_r <= cfg_wdata[0];
      end
      if (ctl.cnt_inc) begin
        count_r   <= count_r + CNT_W'(1);
        next_id_r <= next_id_r + ID_BITS'(1);
      end else if (ctl.cnt_dec) begin
        count_r <= count_m1;
      end
      if (ctl.accept) begin
        if (in_data.cmd == CMD_POP) begin
          st_r <= stat.empty ? ST_EMPTY : ST_POPPED;
        end else begin
          st_r <= stat.full ? ST_FULL : ST_PUSHED;
        end
      end
      pos_r <= pos_nxt;
      if (ctl.best_left) begin
        best_vld_r <= rd_key < item_key;
      end else if (ctl.best_right && (rd_key < best_key)) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  // entry registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_r <= {next_id_r, in_data.new_priority, in_data.new_burst};
    end else if (ctl.moved_ld) begin
      item_r <= rd_data_r;
    end
    if (ctl.top_ld) begin
      top_r <= rd_data_r;
    end
    if (ctl.best_left || (ctl.best_right && (rd_key < best_key))) begin
      best_r     <= rd_data_r;
      best_pos_r <= ctl.best_left ? left_w[CNT_W-1:0] : right_w[CNT_W-1:0];
    end
  end

  // result source
  always_comb begin
    case (st_r)
      ST_POPPED: res_src = top_r;
      ST_EMPTY:  res_src = '0;
      default:   res_src = item_r;
    endcase
  end
  assign res_id_ext = 32'(res_src[ENTRY_W-1 -: ID_BITS]);

  // output register, released on transfer
  assign out_free = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.res_ld) begin
      out_data_r.status        <= st_r;
      out_data_r.proc_id       <= res_id_ext[OUT_ID_W-1:0];
      out_data_r.proc_priority <= res_src[BURST_W +: PRIO_W];
      out_data_r.proc_burst    <= res_src[BURST_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to controller
  assign stat.in_pop    = (in_data.cmd == CMD_POP);
  assign stat.full      = (count_r >= CNT_W'(CAPACITY));
  assign stat.empty     = (count_r == '0);
  assign stat.count_one = (count_r == CNT_W'(1));
  assign stat.pos_root  = (pos_r == CNT_W'(1));
  assign stat.parent_le = (rd_key <= item_key);
  assign stat.left_in   = (left_w <= {1'b0, count_r});
  assign stat.right_in  = (right_w <= {1'b0, count_r});
  assign stat.best_vld  = best_vld_r;
  assign stat.out_free  = out_free;

endmodule

/* hdl/process_min_heap_scheduler.sv */
// result path: a full push or a pop on an empty heap goes straight to the result; a push
//   climbs level by level until its parent is not larger or it reaches the root; a pop
//   fetches root and last entry, then sifts down level by level unless it empties the heap
// throughput: one item at a time, the next input can transfer in the cycle after the result
//   loads; at most one heap access a cycle
// reset: rst_n clears the entry count, id counter, key select and control; heap memory kept
// ----------------------------------------------------------------------------
// process_min_heap_scheduler
// binary min-heap of process entries keyed by priority or burst time
// ----------------------------------------------------------------------------
module process_min_heap_scheduler
  import pmhs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // sequencer
  pmhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // heap storage and datapath
  pmhs_dp #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hdl/pmhs_checker.sv */
// ----------------------------------------------------------------------------
// pmhs_checker
// port-level assertions for the process min-heap scheduler
// ----------------------------------------------------------------------------
`include "process_min_heap_scheduler_defines.svh"

module pmhs_checker
  import pmhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  `PMHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // one item in work at a time: no transfer in the cycle after a transfer
  `PMHS_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input taken while busy")

  // pop on empty carries zero fields
  `PMHS_ASSERT_IMPL(a_empty_zero, out_valid && (out_data.status == ST_EMPTY), (out_data.proc_id == '0) && (out_data.proc_priority == '0) && (out_data.proc_burst == '0), "empty result not zero")

  // a new result appears only after the block was busy
  `PMHS_ASSERT_IMPL(a_res_after_work, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind process_min_heap_scheduler pmhs_checker u_chk (.*);
